// ===== rtl/sbh_pkg.sv =====
// Shared types and constants for the stripe bin histogram.
// No dependencies.
`default_nettype none
package sbh_pkg;
  localparam int NUM_BINS = 64;
  localparam int BIN_W    = 6;
  localparam int COUNT_W  = 32;
  localparam int COORD_W  = 64;
  localparam int LEN_W    = 32;
  localparam int ACT_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd2;
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [COORD_W-1:0] dividend;
    logic [LEN_W-1:0]   divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ===== rtl/sbh_if.sv =====
// Valid/ready channel interfaces for the histogram input and result beats.
// Depends on sbh_pkg.
`default_nettype none
interface sbh_in_if (input wire logic clk);
  import sbh_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  logic signed [COORD_W-1:0] coordinate;
  logic [BIN_W-1:0] read_bin;
  modport source (output valid, kind, coordinate, read_bin, input ready);
  modport sink (input valid, kind, coordinate, read_bin, output ready);
endinterface

interface sbh_out_if (input wire logic clk);
  import sbh_pkg::*;
  logic valid;
  logic ready;
  logic [BIN_W-1:0] bin_index;
  logic [COUNT_W-1:0] bin_count;
  logic overflowed;
  modport source (output valid, bin_index, bin_count, overflowed, input ready);
  modport sink (input valid, bin_index, bin_count, overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbh_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, 64-bit by 32-bit.
// Depends on sbh_pkg.
`default_nettype none
module sbh_divider (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sbh_pkg::div_req_t req,
  output logic done,
  output logic [sbh_pkg::COORD_W-1:0] quotient
);
  import sbh_pkg::*;
  logic [COORD_W-1:0] q_r, q_nxt;
  logic [LEN_W:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] dvs_r, dvs_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [LEN_W:0] trial;
  logic [LEN_W:0] shifted;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[LEN_W-1:0], q_r[COORD_W-1]};
    trial = shifted - {1'b0, dvs_r};
    if (req.start) begin
      q_nxt = req.dividend; rem_nxt = '0; dvs_nxt = req.divisor;
      cnt_nxt = 7'(COORD_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[LEN_W]) begin
        rem_nxt = trial; q_nxt = {q_r[COORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted; q_nxt = {q_r[COORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      // flag done once the last quotient bit has landed in q_r
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== rtl/sbh_count_mem.sv =====
// Bin counter memory: one write port, one read port, registered read data.
// Depends on sbh_pkg.
`default_nettype none
module sbh_count_mem (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [sbh_pkg::BIN_W-1:0] waddr,
  input  wire logic [sbh_pkg::COUNT_W-1:0] wdata,
  input  wire logic [sbh_pkg::BIN_W-1:0] raddr,
  output logic [sbh_pkg::COUNT_W-1:0] rdata
);
  import sbh_pkg::*;
  logic [COUNT_W-1:0] mem [NUM_BINS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/stripe_bin_histogram.sv =====
// Stripe bin histogram top level: control sequencer, divider and counter memory.
// Depends on sbh_pkg, sbh_if, sbh_divider and sbh_count_mem.
//
// Input channel in_: a count beat (kind 0) bins a signed coordinate into a
// stripe and increments that bin's saturating counter; a read beat (kind 1)
// returns one bin's count. Every input beat yields exactly one result beat on
// out_ with the bin index, its count after the beat and the overflow flag.
// Configuration via cfg_we/cfg_idx/cfg_data: the user must write it only while the
// block is idle; the block itself does not enforce this. One item at a time: a
// count beat runs the divider through all 64 quotient bits, hands over the
// quotient, then goes through memory read, write and output; a read beat, or a
// count beat below the stripe start, skips the divider. The divider loop sets the
// count rate. After reset a clearing pass zeroes the 64 counters, one per cycle,
// while in_ready stays low; configuration writes are taken throughout.
// A result waits in the output register while out_ready is low; no new beat
// is accepted until it has been taken.
`default_nettype none
module stripe_bin_histogram (
  input  wire logic clk,
  input  wire logic rst_n,
  sbh_in_if.sink    in_ch,
  sbh_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [sbh_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [sbh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbh_pkg::*;

  state_t state_r, state_nxt;
  logic signed [COORD_W-1:0] start_r;
  logic [LEN_W-1:0] len_r;
  logic [ACT_W-1:0] act_r;
  logic [BIN_W-1:0] clr_r;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic kind_r, ovf_r, ovf_nxt;
  logic [COUNT_W-1:0] cnt_out_r;
  div_req_t div_req;
  logic div_done;
  logic [COORD_W-1:0] quot;
  logic mem_we;
  logic [BIN_W-1:0] mem_waddr;
  logic [COUNT_W-1:0] mem_wdata, mem_rdata, inc;
  logic [ACT_W-1:0] act_eff;
  logic [BIN_W-1:0] last_bin;
  logic accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign act_eff = (act_r == '0) ? ACT_W'(1) :
                   (act_r > ACT_W'(NUM_BINS)) ? ACT_W'(NUM_BINS) : act_r;
  assign last_bin = BIN_W'(act_eff - ACT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0; len_r <= LEN_W'(1); act_r <= ACT_W'(NUM_BINS);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START:  start_r <= cfg_data;
        REG_LENGTH: len_r <= cfg_data[LEN_W-1:0];
        REG_ACTIVE: act_r <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == BIN_W'(NUM_BINS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.kind == KIND_READ) state_nxt = ST_READ;
          else if (in_ch.coordinate < start_r) state_nxt = ST_READ;
          else state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (div_done) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // bin selection
  always_comb begin
    bin_nxt = bin_r;
    ovf_nxt = ovf_r;
    if (state_r == ST_IDLE && accept) begin
      if (in_ch.kind == KIND_READ) begin
        bin_nxt = in_ch.read_bin; ovf_nxt = 1'b0;
      end else begin
        bin_nxt = '0; ovf_nxt = (in_ch.coordinate < start_r);
      end
    end else if (state_r == ST_DIV && div_done) begin
      if (quot >= COORD_W'(act_eff)) begin
        bin_nxt = last_bin; ovf_nxt = 1'b1;
      end else begin
        bin_nxt = quot[BIN_W-1:0]; ovf_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    div_req.start = (state_r == ST_IDLE) && accept && (in_ch.kind == KIND_COUNT)
                    && !(in_ch.coordinate < start_r);
    div_req.dividend = COORD_W'(in_ch.coordinate - start_r);
    div_req.divisor = (len_r == '0) ? LEN_W'(1) : len_r;
  end

  assign inc = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_W'(1);

  // counter memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = bin_r;
    mem_wdata = inc;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1; mem_waddr = clr_r; mem_wdata = '0;
    end else if (state_r == ST_WRITE && kind_r == KIND_COUNT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + BIN_W'(1);
    end
    bin_r <= bin_nxt;
    ovf_r <= ovf_nxt;
    if (accept) begin
      kind_r <= in_ch.kind;
    end
    if (state_r == ST_WRITE) cnt_out_r <= (kind_r == KIND_COUNT) ? inc : mem_rdata;
  end

  sbh_divider u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(quot)
  );

  sbh_count_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(bin_r), .rdata(mem_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.bin_index = bin_r;
  assign out_ch.bin_count = cnt_out_r;
  assign out_ch.overflowed = ovf_r;
endmodule
`default_nettype wire

// ===== tb/tb_stripe_bin_histogram.sv =====
// Self-checking testbench for the stripe bin histogram: directed table and configuration cases, then random beats.
// Depends on sbh_pkg, sbh_if and the stripe_bin_histogram RTL.
`default_nettype none
module tb;
  import sbh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // register index beyond the list, written to check it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct {
    logic                      kind;
    logic signed [COORD_W-1:0] coord;
    logic [BIN_W-1:0]          rbin;
    logic                      known;
    logic [BIN_W-1:0]          x_bin;
    logic [COUNT_W-1:0]        x_count;
    logic                      x_ovf;
  } stim_t;

  typedef struct {
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sbh_in_if  in_ch (clk);
  sbh_out_if out_ch (clk);

  stripe_bin_histogram i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [COORD_W-1:0] start_q;
  logic [LEN_W-1:0]          length_q;
  logic [ACT_W-1:0]          active_q;
  logic [COUNT_W-1:0]        counts_q [NUM_BINS];

  result_t pending_results[$];
  int      mismatches;
  bit      sender_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic result_t bin_and_count(logic kind, logic signed [COORD_W-1:0] coord,
                                            logic [BIN_W-1:0] rbin);
    result_t r;
    logic [63:0] act;
    logic [63:0] diff;
    logic [63:0] len;
    logic [63:0] b;
    r.ovf = 1'b0;
    if (kind == KIND_READ) begin
      r.bin = rbin;
      r.count = counts_q[rbin];
      return r;
    end
    act = (active_q == 0) ? 64'd1 : (active_q > NUM_BINS) ? 64'(NUM_BINS) : 64'(active_q);
    if (coord < start_q) begin
      b = '0;
      r.ovf = 1'b1;
    end else begin
      diff = coord - start_q;
      len = (length_q == 0) ? 64'd1 : 64'(length_q);
      b = diff / len;
      if (b >= act) begin
        b = act - 64'd1;
        r.ovf = 1'b1;
      end
    end
    if (counts_q[b] != COUNT_MAX) counts_q[b] = counts_q[b] + COUNT_W'(1);
    r.bin = b[BIN_W-1:0];
    r.count = counts_q[b];
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_START:  start_q = data;
      REG_LENGTH: length_q = data[LEN_W-1:0];
      REG_ACTIVE: active_q = data[ACT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // drive one beat, with a random gap between bursts
  int burst_left;
  task automatic send_beat(stim_t s);
    result_t r;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.kind = s.kind;
    in_ch.coordinate = s.coord;
    in_ch.read_bin = s.rbin;
    do @(posedge clk); while (!in_ch.ready);
    r = bin_and_count(s.kind, s.coord, s.rbin);
    if (s.known) begin
      r.bin = s.x_bin;
      r.count = s.x_count;
      r.ovf = s.x_ovf;
    end
    pending_results = {pending_results, r};
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic stim_t cnt(logic signed [COORD_W-1:0] c);
    stim_t s;
    s.kind = KIND_COUNT; s.coord = c; s.rbin = BIN_W'($urandom); s.known = 1'b0;
    return s;
  endfunction

  function automatic stim_t rd(logic [BIN_W-1:0] b);
    stim_t s;
    s.kind = KIND_READ; s.coord = {$urandom, $urandom}; s.rbin = b; s.known = 1'b0;
    return s;
  endfunction

  function automatic stim_t known(stim_t s, logic [BIN_W-1:0] b, logic [COUNT_W-1:0] c,
                                  logic o);
    s.known = 1'b1; s.x_bin = b; s.x_count = c; s.x_ovf = o;
    return s;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (mode)
      0: return start_q + 64'($urandom_range(0, 300)) * 64'(length_q) - 64'($urandom_range(0, 3));
      1: return v;
      2: return start_q - 64'($urandom_range(1, 5));
      default: return start_q + (v >> $urandom_range(0, 63));
    endcase
  endfunction

  // result checker with a receiver stall pattern
  int stall_phase;
  always @(posedge clk) begin
    result_t x;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat bin=%0d", out_ch.bin_index);
      end else begin
        x = pending_results.pop_front();
        if (out_ch.bin_index !== x.bin || out_ch.bin_count !== x.count ||
            out_ch.overflowed !== x.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bin/count/ovf expected %0d/%0d/%0b got %0d/%0d/%0b",
                     x.bin, x.count, x.ovf,
                     out_ch.bin_index, out_ch.bin_count, out_ch.overflowed);
        end
      end
    end
  end

  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    // stretches of free flow alternate with patterned stalls
    if (stall_phase[9]) out_ch.ready <= 1'b1;
    else out_ch.ready <= (stall_phase % 5 != 1) && ($urandom_range(0, 3) != 0);
  end

  stim_t dir_tab[$];

  initial begin
    int i;
    int n;
    logic [63:0] big;
    stall_phase = 0;
    mismatches = 0;
    burst_left = 0;
    sender_done = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_COUNT;
    in_ch.coordinate = '0;
    in_ch.read_bin = '0;
    out_ch.ready = 1'b0;
    start_q = 0;
    length_q = 1;
    active_q = 64;
    for (i = 0; i < NUM_BINS; i++) counts_q[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: start 0, length 1, 64 bins
    dir_tab = {dir_tab, known(rd(6'd0), 6'd0, 32'd0, 1'b0)};
    dir_tab = {dir_tab, known(rd(6'd63), 6'd63, 32'd0, 1'b0)};
    dir_tab = {dir_tab, known(cnt(64'sd0), 6'd0, 32'd1, 1'b0)};
    dir_tab = {dir_tab, known(cnt(64'sd63), 6'd63, 32'd1, 1'b0)};
    dir_tab = {dir_tab, known(cnt(64'sd64), 6'd63, 32'd2, 1'b1)};
    dir_tab = {dir_tab, known(cnt(-64'sd1), 6'd0, 32'd2, 1'b1)};
    dir_tab = {dir_tab, known(cnt(64'h8000_0000_0000_0000), 6'd0, 32'd3, 1'b1)};
    dir_tab = {dir_tab, known(cnt(64'h7FFF_FFFF_FFFF_FFFF), 6'd63, 32'd3, 1'b1)};
    dir_tab = {dir_tab, known(rd(6'd63), 6'd63, 32'd3, 1'b0)};
    dir_tab = {dir_tab, cnt(64'sd17)};
    foreach (dir_tab[k]) send_beat(dir_tab[k]);
    drain();

    // narrow histogram; bin equal to active count overflows, upper bins still readable
    write_reg(REG_ACTIVE, 64'd4);
    write_reg(REG_LENGTH, 64'd10);
    write_reg(REG_START, -64'sd100);
    send_beat(cnt(-64'sd100));
    send_beat(cnt(-64'sd61));
    send_beat(cnt(-64'sd60));
    send_beat(cnt(-64'sd101));
    send_beat(rd(6'd63));
    send_beat(rd(6'd17));
    drain();
    // zero length, zero and oversized active count, extreme start and length
    write_reg(REG_LENGTH, 64'd0);
    write_reg(REG_ACTIVE, 64'd0);
    send_beat(cnt(-64'sd50));
    drain();
    write_reg(REG_NONE, 64'hFFFF);
    write_reg(REG_ACTIVE, 64'd127);
    write_reg(REG_START, 64'h8000_0000_0000_0000);
    write_reg(REG_LENGTH, 64'hFFFF_FFFF);
    send_beat(cnt(64'h7FFF_FFFF_FFFF_FFFF));
    send_beat(cnt(64'h8000_0000_0000_0000));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 7; ph++) begin
      big = {$urandom, $urandom};
      case (ph)
        0: begin write_reg(REG_START, 64'sd0); write_reg(REG_LENGTH, 64'd1);
                 write_reg(REG_ACTIVE, 64'd64); end
        1: begin write_reg(REG_START, big); write_reg(REG_LENGTH, 64'($urandom_range(1, 40)));
                 write_reg(REG_ACTIVE, 64'($urandom_range(1, 64))); end
        2: begin write_reg(REG_ACTIVE, 64'd1); end
        3: begin write_reg(REG_START, 64'h7FFF_FFFF_FFFF_FFFF); write_reg(REG_ACTIVE, 64'd64); end
        4: begin write_reg(REG_START, -64'sd5); write_reg(REG_LENGTH, 64'd3);
                 write_reg(REG_ACTIVE, 64'd65); end
        5: begin write_reg(REG_LENGTH, {$urandom, $urandom}); write_reg(REG_START, big); end
        default: begin write_reg(REG_START, -64'sd1000); write_reg(REG_LENGTH, 64'd7);
                 write_reg(REG_ACTIVE, 64'($urandom_range(0, 127))); end
      endcase
      n = 200;
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) send_beat(rd(BIN_W'($urandom)));
        else send_beat(cnt(rand_coord($urandom_range(0, 4))));
        // hold until every result is back once per phase
        if (i == n / 2) while (pending_results.size() != 0) @(negedge clk);
      end
      drain();
    end
    sender_done = 1'b1;
  end

  initial begin
    wait (sender_done);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
